@@ hw/rtl/yuv565_pkg.sv @@
// ----------------------------------------------------------------------------
// yuv565_pkg
// Constants and helpers for the YUV to dithered RGB565 converter.
// ----------------------------------------------------------------------------
package yuv565_pkg;

    localparam int unsigned SampleW = 8;
    localparam int unsigned PhaseW  = 2;
    localparam int unsigned PixelW  = 16;

    // Limited-range luma expansion
    localparam logic signed [8:0]  LumaOffset = 9'sd16;
    localparam logic signed [9:0]  LumaGain   = 10'sd298;

    // BT.601 chroma coefficients, scaled by 1024
    localparam logic signed [8:0]  ChromaOffset = 9'sd128;
    localparam logic signed [11:0] CoefRedV     = 12'sd1436;
    localparam logic signed [11:0] CoefGreenU   = -12'sd352;
    localparam logic signed [11:0] CoefGreenV   = -12'sd731;
    localparam logic signed [11:0] CoefBlueU    = 12'sd1815;

    typedef logic signed [11:0] wide_t;
    typedef logic signed [4:0]  dither_t;

    // Signed 4x4 ordered-dither matrix, indexed by row then column
    function automatic dither_t bayer_value(input logic [PhaseW-1:0] row,
                                            input logic [PhaseW-1:0] col);
        dither_t d;
        d = 5'sd0;
        case ({row, col})
            4'h0: d = -5'sd8;
            4'h1: d =  5'sd0;
            4'h2: d = -5'sd6;
            4'h3: d =  5'sd2;
            4'h4: d =  5'sd4;
            4'h5: d = -5'sd4;
            4'h6: d =  5'sd6;
            4'h7: d = -5'sd2;
            4'h8: d = -5'sd5;
            4'h9: d =  5'sd3;
            4'hA: d = -5'sd7;
            4'hB: d =  5'sd1;
            4'hC: d =  5'sd7;
            4'hD: d = -5'sd1;
            4'hE: d =  5'sd5;
            4'hF: d = -5'sd3;
            default: d = 5'sd0;
        endcase
        return d;
    endfunction

    // Saturate a signed value to 0..255
    function automatic logic [SampleW-1:0] clamp_u8(input wide_t v);
        logic [SampleW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > wide_t'(255))
            r = '1;
        else
            r = v[SampleW-1:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/yuv_to_rgb565_dither_core.sv @@
// Pipeline: the accepting edge loads the input register; done and pixel_565 come
// from the result register, which is loaded from the input register.
// Throughput: one pixel per clock; busy is held low, so start may stay high.
// The input register and the result register bound the single conversion pass.
// Reset: rst_n clears the valid flags at once; the data registers are not reset.
// ----------------------------------------------------------------------------
// yuv_to_rgb565_dither_core
// Limited-range YUV pixel to ordered-dither RGB565 word, one pixel per clock.
// ----------------------------------------------------------------------------
module yuv_to_rgb565_dither_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [yuv565_pkg::SampleW-1:0] luma,
    input  logic [yuv565_pkg::SampleW-1:0] chroma_blue,
    input  logic [yuv565_pkg::SampleW-1:0] chroma_red,
    input  logic [yuv565_pkg::PhaseW-1:0]  column_phase,
    input  logic [yuv565_pkg::PhaseW-1:0]  row_phase,
    output logic                           done,
    output logic [yuv565_pkg::PixelW-1:0]  pixel_565
);
    import yuv565_pkg::*;

    logic                in_vld_reg;
    logic [SampleW-1:0]  luma_reg;
    logic [SampleW-1:0]  cb_reg;
    logic [SampleW-1:0]  cr_reg;
    logic [PhaseW-1:0]   col_reg;
    logic [PhaseW-1:0]   row_reg;
    logic                done_reg;
    logic [PixelW-1:0]   pixel_reg;
    logic [PixelW-1:0]   pixel_next;
    logic                accept;

    // every cycle is free: the pipeline never holds
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
            done_reg   <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            luma_reg <= luma;
            cb_reg   <= chroma_blue;
            cr_reg   <= chroma_red;
            col_reg  <= column_phase;
            row_reg  <= row_phase;
        end
        if (in_vld_reg)
        begin
            pixel_reg <= pixel_next;
        end
    end

    yuv565_pixel_math u_math (
        .luma         (luma_reg),
        .chroma_blue  (cb_reg),
        .chroma_red   (cr_reg),
        .column_phase (col_reg),
        .row_phase    (row_reg),
        .pixel_565    (pixel_next)
    );

    assign done      = done_reg;
    assign pixel_565 = pixel_reg;

`ifndef ASSERT_OFF
    a_word_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted word not delivered after two cycles");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_vld_reg))
        else $error("done without a word in the input register");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |=> done_reg)
        else $error("input register word did not advance to result");
`endif

endmodule

@@ hw/rtl/yuv565_pixel_math.sv @@
// ----------------------------------------------------------------------------
// yuv565_pixel_math
// Combinational colour conversion, dither and 5-6-5 packing of one pixel.
// ----------------------------------------------------------------------------
module yuv565_pixel_math (
    input  logic [yuv565_pkg::SampleW-1:0] luma,
    input  logic [yuv565_pkg::SampleW-1:0] chroma_blue,
    input  logic [yuv565_pkg::SampleW-1:0] chroma_red,
    input  logic [yuv565_pkg::PhaseW-1:0]  column_phase,
    input  logic [yuv565_pkg::PhaseW-1:0]  row_phase,
    output logic [yuv565_pkg::PixelW-1:0]  pixel_565
);
    import yuv565_pkg::*;

    logic signed [8:0]  y_diff;
    logic signed [8:0]  u_diff;
    logic signed [8:0]  v_diff;
    logic signed [18:0] y_prod;
    logic signed [20:0] rv_prod;
    logic signed [20:0] gu_prod;
    logic signed [20:0] gv_prod;
    logic signed [20:0] bu_prod;
    logic [7:0]         y_full;
    wide_t              r_sum;
    wide_t              g_sum;
    wide_t              b_sum;
    logic [7:0]         r_sat;
    logic [7:0]         g_sat;
    logic [7:0]         b_sat;
    wide_t              dith;
    logic [7:0]         r_out;
    logic [7:0]         g_out;
    logic [7:0]         b_out;

    always_comb
    begin
        y_diff  = $signed({1'b0, luma}) - LumaOffset;
        u_diff  = $signed({1'b0, chroma_blue}) - ChromaOffset;
        v_diff  = $signed({1'b0, chroma_red}) - ChromaOffset;

        y_prod  = y_diff * LumaGain;
        rv_prod = v_diff * CoefRedV;
        gu_prod = u_diff * CoefGreenU;
        gv_prod = v_diff * CoefGreenV;
        bu_prod = u_diff * CoefBlueU;

        // drop the fraction bits: floor division by 256 and by 1024
        y_full  = clamp_u8({y_prod[18], y_prod[18:8]});

        r_sum   = $signed({4'b0, y_full}) + {rv_prod[20], rv_prod[20:10]};
        g_sum   = $signed({4'b0, y_full}) + {gu_prod[20], gu_prod[20:10]}
                  + {gv_prod[20], gv_prod[20:10]};
        b_sum   = $signed({4'b0, y_full}) + {bu_prod[20], bu_prod[20:10]};

        r_sat   = clamp_u8(r_sum);
        g_sat   = clamp_u8(g_sum);
        b_sat   = clamp_u8(b_sum);

        dith    = wide_t'(bayer_value(row_phase, column_phase));
        r_out   = clamp_u8($signed({4'b0, r_sat}) + dith);
        g_out   = clamp_u8($signed({4'b0, g_sat}) + dith);
        b_out   = clamp_u8($signed({4'b0, b_sat}) + dith);

        pixel_565 = {r_out[7:3], g_out[7:2], b_out[7:3]};
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YUV to dithered RGB565 converter. Pixels go in
// on start/busy with random idle gaps; each word on done is compared with a
// fixed-point BT.601 plus 4x4 ordered-dither prediction held in a FIFO.
// ----------------------------------------------------------------------------
module tb_top;

    import yuv565_pkg::*;

    localparam int ClkPeriod   = 10;
    localparam int CycleLimit  = 200000;
    localparam int ReportLimit = 10;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [SampleW-1:0] luma;
    logic [SampleW-1:0] chroma_blue;
    logic [SampleW-1:0] chroma_red;
    logic [PhaseW-1:0]  column_phase;
    logic [PhaseW-1:0]  row_phase;
    logic               done;
    logic [PixelW-1:0]  pixel_565;

    logic [PixelW-1:0]  pixel_expect_q[$];
    int                 mismatch_count;
    int                 cycle_count;
    bit                 stream_no_gaps;

    // Ordered-dither offsets, [row][column]
    int bayer_offset[4][4] = '{
        '{-8,  0, -6,  2},
        '{ 4, -4,  6, -2},
        '{-5,  3, -7,  1},
        '{ 7, -1,  5, -3}
    };

    yuv_to_rgb565_dither_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .luma         (luma),
        .chroma_blue  (chroma_blue),
        .chroma_red   (chroma_red),
        .column_phase (column_phase),
        .row_phase    (row_phase),
        .done         (done),
        .pixel_565    (pixel_565)
    );

    initial
    begin
        clk = 1'b0;
        forever #(ClkPeriod / 2) clk = ~clk;
    end

    function automatic int clamp_channel(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    // floor(coef * (c - 128) / 1024)
    function automatic int chroma_contrib(input int coef, input logic [SampleW-1:0] c);
        return (coef * (int'(c) - 128)) >>> 10;
    endfunction

    function automatic logic [PixelW-1:0] predict_rgb565(
        input logic [SampleW-1:0] y,
        input logic [SampleW-1:0] u,
        input logic [SampleW-1:0] v,
        input logic [PhaseW-1:0]  col,
        input logic [PhaseW-1:0]  row
    );
        int                 y_full;
        int                 d;
        logic [SampleW-1:0] r8;
        logic [SampleW-1:0] g8;
        logic [SampleW-1:0] b8;
        y_full = clamp_channel(((int'(y) - 16) * 298) >>> 8);
        d  = bayer_offset[row][col];
        r8 = SampleW'(clamp_channel(clamp_channel(y_full + chroma_contrib(1436, v)) + d));
        g8 = SampleW'(clamp_channel(clamp_channel(y_full + chroma_contrib(-352, u)
                                                  + chroma_contrib(-731, v)) + d));
        b8 = SampleW'(clamp_channel(clamp_channel(y_full + chroma_contrib(1815, u)) + d));
        return {r8[7:3], g8[7:2], b8[7:3]};
    endfunction

    // Hold start high between back-to-back words; lower it only for a gap.
    task automatic send_pixel(
        input logic [SampleW-1:0] y,
        input logic [SampleW-1:0] u,
        input logic [SampleW-1:0] v,
        input logic [PhaseW-1:0]  col,
        input logic [PhaseW-1:0]  row
    );
        int gap;
        gap = stream_no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        luma         <= y;
        chroma_blue  <= u;
        chroma_red   <= v;
        column_phase <= col;
        row_phase    <= row;
        do
            @(posedge clk);
        while (busy);
        pixel_expect_q.push_back(predict_rgb565(y, u, v, col, row));
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pixel_expect_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic test_luma_extremes();
        send_pixel(8'd0,   8'd128, 8'd128, 2'd0, 2'd0);
        send_pixel(8'd15,  8'd128, 8'd128, 2'd1, 2'd1);
        send_pixel(8'd236, 8'd128, 8'd128, 2'd2, 2'd2);
        send_pixel(8'd255, 8'd128, 8'd128, 2'd3, 2'd3);
    endtask

    task automatic test_chroma_extremes();
        send_pixel(8'd128, 8'd0,   8'd0,   2'd0, 2'd3);
        send_pixel(8'd128, 8'd0,   8'd255, 2'd3, 2'd0);
        send_pixel(8'd128, 8'd255, 8'd0,   2'd1, 2'd2);
        send_pixel(8'd128, 8'd255, 8'd255, 2'd2, 2'd1);
    endtask

    // Black or white on every dither phase (white on odd columns, black on even), so both clamps after the dither bite
    task automatic test_black_white_phases();
        for (int p = 0; p < 16; p++)
            send_pixel(p[0] ? 8'd235 : 8'd16, 8'd128, 8'd128, p[1:0], p[3:2]);
    endtask

    task automatic test_streaming(input int count);
        stream_no_gaps = 1'b1;
        repeat (count)
            send_pixel(SampleW'($urandom), SampleW'($urandom), SampleW'($urandom),
                       PhaseW'($urandom), PhaseW'($urandom));
        stream_no_gaps = 1'b0;
    endtask

    task automatic test_random_pixels(input int count);
        logic [SampleW-1:0] y;
        logic [SampleW-1:0] u;
        logic [SampleW-1:0] v;
        repeat (count)
        begin
            // Mostly nominal video levels, with full-range samples mixed in
            if ($urandom_range(0, 3) == 0)
            begin
                y = SampleW'($urandom);
                u = SampleW'($urandom);
                v = SampleW'($urandom);
            end
            else
            begin
                y = SampleW'($urandom_range(16, 235));
                u = SampleW'($urandom_range(16, 240));
                v = SampleW'($urandom_range(16, 240));
            end
            send_pixel(y, u, v, PhaseW'($urandom), PhaseW'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pixel_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= ReportLimit)
                    $display("unexpected pixel word %h at cycle %0d", pixel_565, cycle_count);
            end
            else
            begin
                logic [PixelW-1:0] want;
                want = pixel_expect_q.pop_front();
                if (pixel_565 !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= ReportLimit)
                        $display("pixel_565 mismatch: expected %h, got %h at cycle %0d",
                                 want, pixel_565, cycle_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        luma           = '0;
        chroma_blue    = '0;
        chroma_red     = '0;
        column_phase   = '0;
        row_phase      = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        stream_no_gaps = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_luma_extremes();
        test_chroma_extremes();
        test_black_white_phases();
        test_streaming(100);
        test_random_pixels(460);
        wait_results_drained();
        test_random_pixels(460);
        wait_results_drained();
        repeat (6) @(posedge clk);

        if (mismatch_count == 0 && pixel_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
